>>> hdl/tblm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tblm_pkg
// Shared constants, widths and helpers for the three-band level meter.
// ----------------------------------------------------------------------------
package tblm_pkg;

    localparam int MaxChannels  = 8;
    localparam int CoefFracBits = 30;
    localparam int EnvFracBits  = 24;
    localparam int FollowFrac   = 24;

    localparam int SampleW = 16;
    localparam int LevelW  = 17;
    localparam int EnvW    = 26;
    localparam int DelayW  = 40;
    localparam int SumW    = 20;
    localparam int ProdW   = 66;

    localparam int BxShift  = CoefFracBits + 15 - EnvFracBits;
    localparam int A1Shift  = CoefFracBits;
    localparam int B0yShift = CoefFracBits - 1;
    localparam int LvlShift = EnvFracBits - 16;

    localparam logic [EnvW-1:0]   EnvMax   = {EnvW{1'b1}};
    localparam logic [LevelW-1:0] LevelOne = 17'd65536;

    // Configuration register indexes
    localparam logic [2:0] CFG_CHANNEL_COUNT = 3'd0;
    localparam logic [2:0] CFG_LOW_COEF      = 3'd1;
    localparam logic [2:0] CFG_MID_COEF      = 3'd2;
    localparam logic [2:0] CFG_HIGH_COEF     = 3'd3;
    localparam logic [2:0] CFG_ATTACK        = 3'd4;
    localparam logic [2:0] CFG_RELEASE       = 3'd5;

    typedef logic signed [ProdW:0] t_wide;

    // Round to nearest, ties toward +infinity, then arithmetic shift.
    function automatic t_wide rnd(input t_wide v, input int s);
        t_wide half;
        half = t_wide'(1) <<< (s - 1);
        return (v + half) >>> s;
    endfunction

    function automatic logic signed [31:0] sat32(input t_wide v);
        if (v > t_wide'(64'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
        if (v < -t_wide'(64'sh8000_0000)) return -32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic signed [DelayW-1:0] sat40(input t_wide v);
        if (v > t_wide'(64'sh7F_FFFF_FFFF)) return 40'sh7F_FFFF_FFFF;
        if (v < -t_wide'(64'sh80_0000_0000)) return 40'sh80_0000_0000;
        return v[DelayW-1:0];
    endfunction

endpackage
`default_nettype wire

>>> hdl/tblm_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tblm_in_if
// Sample channel: one interleaved sample and its end-of-buffer flag per beat.
// ----------------------------------------------------------------------------
interface tblm_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [tblm_pkg::SampleW-1:0]  sample;
    logic                                 end_of_buffer;

    modport source (output valid, output sample, output end_of_buffer, input ready);
    modport sink   (input valid, input sample, input end_of_buffer, output ready);
endinterface
`default_nettype wire

>>> hdl/tblm_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tblm_out_if
// Level channel: three band levels in Q1.16 per beat.
// ----------------------------------------------------------------------------
interface tblm_out_if;
    logic                          valid;
    logic                          ready;
    logic [tblm_pkg::LevelW-1:0]   low_level;
    logic [tblm_pkg::LevelW-1:0]   mid_level;
    logic [tblm_pkg::LevelW-1:0]   high_level;

    modport source (output valid, output low_level, output mid_level, output high_level,
                    input ready);
    modport sink   (input valid, input low_level, input mid_level, input high_level,
                    output ready);
endinterface
`default_nettype wire

>>> hdl/three_band_level_meter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// three_band_level_meter
// Three bandpass biquads with envelope followers, published per buffer.
// ----------------------------------------------------------------------------
// Samples arrive interleaved; channel_count of them form a frame that is
// averaged into one mono value. A sample that does not close a frame is only
// accumulated. A sample that closes a frame is accepted, goes through the
// bit-serial divider that forms the rounded average, then through S_BX, S_Y,
// S_D1, S_D2 and S_ENV for each band on the one shared 33x33 multiplier (three
// filter products and one follower product, each registered); an end-of-buffer
// beat adds a publish state, which waits while the level register still holds
// an untaken beat. The sample channel is not ready while a frame is being
// processed. A zero channel count drops samples without effect. Configuration
// is taken at any edge with i_cfg_we high and must only be written while idle.
// ----------------------------------------------------------------------------
module three_band_level_meter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    tblm_in_if.sink          i_in,
    tblm_out_if.source       o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_BX, S_Y, S_D1, S_D2, S_ENV, S_PUB
    } t_state;

    typedef logic signed [tblm_pkg::ProdW:0] t_wide;

    t_state r_state;

    // configuration
    logic [3:0]  r_count;
    logic [63:0] r_coef [0:2];
    logic [23:0] r_atk, r_rel;

    // frame and filter state
    logic [3:0]                          r_pos;
    logic signed [tblm_pkg::SumW-1:0]    r_sum;
    logic signed [tblm_pkg::DelayW-1:0]  r_d1 [0:2];
    logic signed [tblm_pkg::DelayW-1:0]  r_d2 [0:2];
    logic [tblm_pkg::EnvW-1:0]           r_env [0:2];

    // sequencer working registers
    logic        r_eob, r_neg;
    logic [4:0]  r_rem, r_it;
    logic [3:0]  r_cnt;
    logic [19:0] r_num, r_quo;
    logic [1:0]  r_band;
    logic signed [15:0]              r_x;
    logic signed [33:0]              r_bx;
    logic signed [31:0]              r_y;
    logic [tblm_pkg::EnvW-1:0]       r_r;
    logic signed [tblm_pkg::ProdW-1:0] r_prod;

    logic        r_ovalid;
    logic [16:0] r_low, r_mid, r_high;

    // ---------------------------------------------------------------- accept
    logic        in_fire;
    logic [3:0]  cnt_eff, pos_n;
    logic signed [tblm_pkg::SumW-1:0] sum_n;
    logic [19:0] mag_n;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;

    always_comb begin
        cnt_eff = (r_count > 4'(tblm_pkg::MaxChannels)) ? 4'(tblm_pkg::MaxChannels) : r_count;
        sum_n   = r_sum + tblm_pkg::SumW'(i_in.sample);
        pos_n   = r_pos + 4'd1;
        mag_n   = sum_n[tblm_pkg::SumW-1] ? 20'(-sum_n) : 20'(sum_n);
    end

    // ---------------------------------------------------------------- divider
    logic [4:0]  trial;
    logic        qbit;
    logic [19:0] quo_n;
    logic signed [15:0] mono;

    always_comb begin
        trial = {r_rem[3:0], r_num[19]};
        qbit  = (trial >= {1'b0, r_cnt});
        quo_n = {r_quo[18:0], qbit};
        if (r_neg) begin
            mono = (quo_n > 20'd32768) ? -16'sd32768 : 16'(-$signed({1'b0, quo_n}));
        end else begin
            mono = (quo_n > 20'd32767) ? 16'sd32767 : 16'(quo_n);
        end
    end

    // ---------------------------------------------------------------- datapath
    logic signed [31:0] b0, a1;
    logic signed [32:0] ma, mb;
    t_wide              prod_w;
    logic signed [33:0] bx_c;
    logic signed [31:0] y_c;
    logic signed [tblm_pkg::DelayW-1:0] d1_c, d2_c;
    logic [tblm_pkg::EnvW-1:0] r_c, env_cur, env_c;
    logic [23:0]        pole;
    logic signed [26:0] diff;
    t_wide              env_w;

    always_comb begin
        b0      = $signed(r_coef[r_band][63:32]);
        a1      = $signed(r_coef[r_band][31:0]);
        env_cur = r_env[r_band];
        prod_w  = t_wide'(r_prod);
        bx_c    = 34'(tblm_pkg::rnd(prod_w, tblm_pkg::BxShift));
        y_c     = tblm_pkg::sat32(t_wide'(bx_c) + t_wide'(r_d1[r_band]));
        d1_c    = tblm_pkg::sat40(t_wide'(r_d2[r_band])
                                  - tblm_pkg::rnd(prod_w, tblm_pkg::A1Shift));
        d2_c    = tblm_pkg::sat40(-t_wide'(r_bx) - t_wide'(r_y)
                                  + tblm_pkg::rnd(prod_w, tblm_pkg::B0yShift));
        if (r_y[31]) begin
            r_c = (-t_wide'(r_y) > t_wide'(tblm_pkg::EnvMax)) ? tblm_pkg::EnvMax
                                                                : 26'(-r_y);
        end else begin
            r_c = (t_wide'(r_y) > t_wide'(tblm_pkg::EnvMax)) ? tblm_pkg::EnvMax : 26'(r_y);
        end
        pole  = (r_c > env_cur) ? r_atk : r_rel;
        diff  = $signed({1'b0, env_cur}) - $signed({1'b0, r_c});
        env_w = t_wide'({1'b0, r_r}) + tblm_pkg::rnd(prod_w, tblm_pkg::FollowFrac);
        if (env_w < 0) begin
            env_c = '0;
        end else if (env_w > t_wide'(tblm_pkg::EnvMax)) begin
            env_c = tblm_pkg::EnvMax;
        end else begin
            env_c = env_w[tblm_pkg::EnvW-1:0];
        end

        // shared multiplier operands, one product in each of S_BX, S_Y, S_D1 and S_D2
        case (r_state)
            S_BX: begin
                ma = 33'(b0);
                mb = 33'(r_x);
            end
            S_Y: begin
                ma = 33'(a1);
                mb = 33'(y_c);
            end
            S_D1: begin
                ma = 33'(b0);
                mb = 33'(r_y);
            end
            S_D2: begin
                ma = $signed({9'd0, pole});
                mb = 33'(diff);
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    function automatic logic [16:0] level_of(input logic [tblm_pkg::EnvW-1:0] e);
        logic [28:0] x6;
        logic [28:0] v;
        x6 = ({3'd0, e} << 2) + ({3'd0, e} << 1);
        v  = (x6 + (29'd1 << (tblm_pkg::LvlShift - 1))) >> tblm_pkg::LvlShift;
        return (v > 29'(tblm_pkg::LevelOne)) ? tblm_pkg::LevelOne : v[16:0];
    endfunction

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge i_clk) begin
        r_prod <= tblm_pkg::ProdW'(ma * mb);

        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= 4'd1;
            r_coef   <= '{default: '0};
            r_atk    <= '0;
            r_rel    <= '0;
            r_pos    <= '0;
            r_sum    <= '0;
            r_d1     <= '{default: '0};
            r_d2     <= '{default: '0};
            r_env    <= '{default: '0};
            r_band   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tblm_pkg::CFG_CHANNEL_COUNT: r_count   <= i_cfg_data[3:0];
                    tblm_pkg::CFG_LOW_COEF:      r_coef[0] <= i_cfg_data;
                    tblm_pkg::CFG_MID_COEF:      r_coef[1] <= i_cfg_data;
                    tblm_pkg::CFG_HIGH_COEF:     r_coef[2] <= i_cfg_data;
                    tblm_pkg::CFG_ATTACK:        r_atk     <= i_cfg_data[23:0];
                    tblm_pkg::CFG_RELEASE:       r_rel     <= i_cfg_data[23:0];
                    default: ;
                endcase
            end

            // load a new level beat when publishing, else drop the beat once taken
            if (r_state == S_PUB && (!r_ovalid || o_out.ready)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_fire && r_count != 4'd0) begin
                        if (pos_n >= cnt_eff) begin
                            // frame complete: start the rounded average
                            r_num   <= mag_n + 20'(cnt_eff >> 1);
                            r_neg   <= sum_n[tblm_pkg::SumW-1];
                            r_rem   <= '0;
                            r_quo   <= '0;
                            r_it    <= '0;
                            r_cnt   <= cnt_eff;
                            r_eob   <= i_in.end_of_buffer;
                            r_pos   <= '0;
                            r_sum   <= '0;
                            r_state <= S_DIV;
                        end else if (i_in.end_of_buffer) begin
                            // discard the trailing partial frame
                            r_pos   <= '0;
                            r_sum   <= '0;
                            r_state <= S_PUB;
                        end else begin
                            r_pos <= pos_n;
                            r_sum <= sum_n;
                        end
                    end
                end
                S_DIV: begin
                    r_rem <= qbit ? (trial - {1'b0, r_cnt}) : trial;
                    r_quo <= quo_n;
                    r_num <= {r_num[18:0], 1'b0};
                    r_it  <= r_it + 5'd1;
                    if (r_it == 5'd19) begin
                        r_x     <= mono;
                        r_band  <= '0;
                        r_state <= S_BX;
                    end
                end
                S_BX: begin
                    r_state <= S_Y;
                end
                S_Y: begin
                    r_bx    <= bx_c;
                    r_y     <= y_c;
                    r_state <= S_D1;
                end
                S_D1: begin
                    r_d1[r_band] <= d1_c;
                    r_state      <= S_D2;
                end
                S_D2: begin
                    r_d2[r_band] <= d2_c;
                    r_r          <= r_c;
                    r_state      <= S_ENV;
                end
                S_ENV: begin
                    r_env[r_band] <= env_c;
                    if (r_band == 2'd2) begin
                        r_band  <= '0;
                        r_state <= r_eob ? S_PUB : S_IDLE;
                    end else begin
                        r_band  <= r_band + 2'd1;
                        r_state <= S_BX;
                    end
                end
                S_PUB: begin
                    // hold until the level register is free
                    if (!r_ovalid || o_out.ready) begin
                        r_low    <= level_of(r_env[0]);
                        r_mid    <= level_of(r_env[1]);
                        r_high   <= level_of(r_env[2]);
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.low_level  = r_low;
    assign o_out.mid_level  = r_mid;
    assign o_out.high_level = r_high;

    // ---------------------------------------------------------------- checks
    a_band_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_band <= 2'd2)
        else $error("band index out of range");

    a_pos_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_pos < 4'(tblm_pkg::MaxChannels)))
        else $error("frame position not closed");

    a_level_from_publish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_PUB))
        else $error("level beat without publish");

    a_div_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_it == 5'd19) |=> (r_state == S_BX))
        else $error("divider did not hand off to filters");

endmodule
`default_nettype wire

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the three-band level meter: drives interleaved
// sample beats, models the mono average, the three bandpass biquads and the
// envelope followers, and compares every published level beat.
// ----------------------------------------------------------------------------
module testbench;

    typedef struct packed {
        logic [tblm_pkg::LevelW-1:0] low_lvl;
        logic [tblm_pkg::LevelW-1:0] mid_lvl;
        logic [tblm_pkg::LevelW-1:0] high_lvl;
    } t_level_beat;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [2:0] i_cfg_index;
    logic [63:0] i_cfg_data;

    tblm_in_if  smp_ch ();
    tblm_out_if lvl_ch ();

    three_band_level_meter uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (smp_ch.sink),
        .o_out       (lvl_ch.source),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Predictor copy of the configuration and state
    logic [3:0]  chan_count;
    logic [63:0] band_coef [3];
    logic [23:0] attack_c;
    logic [23:0] release_c;
    int unsigned chan_pos;
    longint      frame_acc;
    longint      dly_one [3];
    longint      dly_two [3];
    longint      envelope [3];

    t_level_beat expected_levels [$];
    int          fail_count = 0;
    longint      cycle_count = 0;
    bit          quiet_rx;     // when set, the receiver never stalls
    bit          quiet_tx;     // when set, the sender never idles

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Round to nearest, ties toward +infinity.
    function automatic longint round_sh(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip(longint v, int bits);
        longint hi;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    // Advance one band by one mono value.
    task automatic filter_band(int k, longint x);
        longint b0, a1, bx, y, r, e, c;
        b0 = longint'($signed(band_coef[k][63:32]));
        a1 = longint'($signed(band_coef[k][31:0]));
        bx = round_sh(b0 * x, tblm_pkg::BxShift);
        y  = clip(bx + dly_one[k], 32);
        dly_one[k] = clip(dly_two[k] - round_sh(a1 * y, tblm_pkg::A1Shift), 40);
        dly_two[k] = clip(-bx - y + round_sh(b0 * y, tblm_pkg::B0yShift), 40);
        r = (y < 0) ? -y : y;
        if (r > longint'(tblm_pkg::EnvMax)) r = longint'(tblm_pkg::EnvMax);
        e = envelope[k];
        c = (r > e) ? longint'(attack_c) : longint'(release_c);
        e = r + round_sh(c * (e - r), tblm_pkg::FollowFrac);
        if (e < 0) e = 0;
        if (e > longint'(tblm_pkg::EnvMax)) e = longint'(tblm_pkg::EnvMax);
        envelope[k] = e;
    endtask

    function automatic logic [tblm_pkg::LevelW-1:0] level_of(longint e);
        longint v;
        v = round_sh(e * 6, tblm_pkg::LvlShift);
        if (v < 0) v = 0;
        if (v > 65536) v = 65536;
        return v[tblm_pkg::LevelW-1:0];
    endfunction

    // Work out what one accepted sample beat publishes.
    task automatic predict_levels(logic signed [15:0] smp, logic eob);
        int unsigned cnt;
        longint mag, mono;
        t_level_beat lv;
        cnt = chan_count;
        if (cnt == 0) return;
        if (cnt > tblm_pkg::MaxChannels) cnt = tblm_pkg::MaxChannels;
        frame_acc += longint'(smp);
        chan_pos++;
        if (chan_pos >= cnt) begin
            mag  = (frame_acc < 0) ? -frame_acc : frame_acc;
            mono = (mag + cnt / 2) / cnt;
            if (frame_acc < 0) mono = -mono;
            mono = clip(mono, 16);
            for (int k = 0; k < 3; k++) filter_band(k, mono);
            chan_pos = 0;
            frame_acc = 0;
        end
        if (eob) begin
            chan_pos = 0;
            frame_acc = 0;
            lv.low_lvl  = level_of(envelope[0]);
            lv.mid_lvl  = level_of(envelope[1]);
            lv.high_lvl = level_of(envelope[2]);
            expected_levels.push_back(lv);
        end
    endtask

    function automatic bit idle_now(bit quiet);
        return !quiet && ($urandom_range(99) < 34);
    endfunction

    // Send one sample beat; hold it until taken.
    task automatic send_sample(logic signed [15:0] smp, logic eob);
        while (idle_now(quiet_tx)) begin
            smp_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        smp_ch.valid         <= 1'b1;
        smp_ch.sample        <= smp;
        smp_ch.end_of_buffer <= eob;
        @(posedge i_clk);
        while (!smp_ch.ready) @(posedge i_clk);
        predict_levels(smp, eob);
    endtask

    // Wait until every expected level beat is out, then let the block settle.
    task automatic drain();
        smp_ch.valid <= 1'b0;
        while (expected_levels.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            tblm_pkg::CFG_CHANNEL_COUNT: chan_count = val[3:0];
            tblm_pkg::CFG_LOW_COEF:      band_coef[0] = val;
            tblm_pkg::CFG_MID_COEF:      band_coef[1] = val;
            tblm_pkg::CFG_HIGH_COEF:     band_coef[2] = val;
            tblm_pkg::CFG_ATTACK:        attack_c = val[23:0];
            tblm_pkg::CFG_RELEASE:       release_c = val[23:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Q2.30 pair: b0 on top, a1 below.
    function automatic logic [63:0] coef_pair(int b0, int a1);
        return {b0[31:0], a1[31:0]};
    endfunction

    // Sensible coefficients for the three bands, around 80 Hz, 600 Hz, 4 kHz.
    task automatic load_typical(logic [3:0] cnt);
        write_reg(tblm_pkg::CFG_CHANNEL_COUNT, {60'd0, cnt});
        write_reg(tblm_pkg::CFG_LOW_COEF,  coef_pair(32'sd5_600_000, -32'sd2_136_000_000));
        write_reg(tblm_pkg::CFG_MID_COEF,  coef_pair(32'sd41_000_000, -32'sd2_030_000_000));
        write_reg(tblm_pkg::CFG_HIGH_COEF, coef_pair(32'sd240_000_000, -32'sd1_330_000_000));
        write_reg(tblm_pkg::CFG_ATTACK,  64'd16_400_000);
        write_reg(tblm_pkg::CFG_RELEASE, 64'd16_760_000);
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Reset-time defaults: everything zero, one channel.
    task automatic test_reset_defaults();
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b1);
        send_sample(16'sh0000, 1'b1);   // buffer of one complete frame
        drain();
    endtask

    // Field extremes, rounding ties, partial frames, count lowered mid-frame.
    task automatic test_directed_cases();
        load_typical(4'd2);
        write_reg(tblm_pkg::CFG_ATTACK, 64'd0);     // follower tracks instantly
        write_reg(tblm_pkg::CFG_RELEASE, 64'hFF_FFFF);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh8000, 1'b1);
        send_sample(16'sh0001, 1'b0);     // half tie, positive
        send_sample(16'sh0000, 1'b0);
        send_sample(-16'sd1, 1'b0);       // half tie, negative
        send_sample(16'sh0000, 1'b1);
        send_sample(16'sh1234, 1'b1);     // trailing partial frame dropped
        drain();
        write_reg(tblm_pkg::CFG_CHANNEL_COUNT, 64'd3);
        send_sample(16'sh4000, 1'b0);
        send_sample(16'sh4000, 1'b0);
        drain();
        write_reg(tblm_pkg::CFG_CHANNEL_COUNT, 64'd2); // closes on the next sample
        send_sample(-16'sd5, 1'b1);
        drain();
        write_reg(tblm_pkg::CFG_CHANNEL_COUNT, 64'd0); // beats dropped, no levels
        send_sample(16'sh7FFF, 1'b1);
        send_sample(16'sh8000, 1'b0);
        drain();
        write_reg(tblm_pkg::CFG_CHANNEL_COUNT, 64'd15); // clamped to the maximum
        for (int i = 0; i < 8; i++) send_sample(16'sh7FFF, i == 7);
        drain();
    endtask

    // Unstable and extreme coefficient words exercise the delay saturation.
    task automatic test_saturation();
        write_reg(tblm_pkg::CFG_CHANNEL_COUNT, 64'd1);
        write_reg(tblm_pkg::CFG_LOW_COEF,  64'h7FFF_FFFF_8000_0000);
        write_reg(tblm_pkg::CFG_MID_COEF,  64'h8000_0000_7FFF_FFFF);
        write_reg(tblm_pkg::CFG_HIGH_COEF, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(tblm_pkg::CFG_ATTACK,  64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(tblm_pkg::CFG_RELEASE, 64'd0);
        for (int i = 0; i < 24; i++) send_sample(rand_sample(), (i % 6) == 5);
        drain();
    endtask

    // Random buffers over several settings; mostly whole frames.
    task automatic test_random_buffers(int n_items);
        int left, cnt, frames;
        left = n_items;
        while (left > 0) begin
            if ($urandom_range(3) == 0) begin
                drain();
                cnt = $urandom_range(8);
                if ($urandom_range(1)) load_typical(4'(cnt));
                else begin
                    write_reg(tblm_pkg::CFG_CHANNEL_COUNT, {60'd0, 4'(cnt)});
                    write_reg(tblm_pkg::CFG_LOW_COEF,  {$urandom, $urandom});
                    write_reg(tblm_pkg::CFG_MID_COEF,  {$urandom, $urandom});
                    write_reg(tblm_pkg::CFG_HIGH_COEF, {$urandom, $urandom});
                    write_reg(tblm_pkg::CFG_ATTACK,  {40'd0, 24'($urandom)});
                    write_reg(tblm_pkg::CFG_RELEASE, {40'd0, 24'($urandom)});
                end
                // one in five phases runs with no idling on either side
                quiet_tx = ($urandom_range(4) == 0);
                quiet_rx = quiet_tx;
            end
            cnt = (chan_count == 0) ? 1 : ((chan_count > 8) ? 8 : chan_count);
            frames = $urandom_range(12);
            for (int i = 0; i < frames * cnt; i++) begin
                send_sample(rand_sample(), (i == frames * cnt - 1) && ($urandom_range(3) != 0));
                if (chan_count != 0) left--;
            end
            if ($urandom_range(4) == 0) begin
                send_sample(rand_sample(), 1'b1);   // broken frame or lone eob
                if (chan_count != 0) left--;
            end
            if (chan_count == 0) left -= 4;         // don't spin on dropped beats
        end
        quiet_tx = 1'b0;
        quiet_rx = 1'b0;
        drain();
    endtask

    // Receiver: random stalls, compare each taken level beat.
    always @(posedge i_clk) begin
        t_level_beat got, want;
        if (i_rst_n && lvl_ch.valid && lvl_ch.ready) begin
            got = {lvl_ch.low_level, lvl_ch.mid_level, lvl_ch.high_level};
            if (expected_levels.size() == 0) begin
                $display("%0t: unexpected level beat %h", $time, got);
                fail_count++;
            end else begin
                want = expected_levels.pop_front();
                if (got.low_lvl !== want.low_lvl) begin
                    $display("%0t: low_level expected %0d actual %0d",
                             $time, want.low_lvl, got.low_lvl);
                    fail_count++;
                end
                if (got.mid_lvl !== want.mid_lvl) begin
                    $display("%0t: mid_level expected %0d actual %0d",
                             $time, want.mid_lvl, got.mid_lvl);
                    fail_count++;
                end
                if (got.high_lvl !== want.high_lvl) begin
                    $display("%0t: high_level expected %0d actual %0d",
                             $time, want.high_lvl, got.high_lvl);
                    fail_count++;
                end
            end
        end
        lvl_ch.ready <= !idle_now(quiet_rx);
    end

    // Watchdog: stops the simulation as failed if it runs on too long.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 1_000_000) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        quiet_tx     = 1'b0;
        quiet_rx     = 1'b0;
        chan_count   = 4'd1;
        attack_c     = '0;
        release_c    = '0;
        chan_pos     = 0;
        frame_acc    = 0;
        for (int k = 0; k < 3; k++) begin
            band_coef[k] = '0;
            dly_one[k]   = 0;
            dly_two[k]   = 0;
            envelope[k]  = 0;
        end
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_index          = tblm_pkg::CFG_CHANNEL_COUNT;
        i_cfg_data           = '0;
        smp_ch.valid         = 1'b0;
        smp_ch.sample        = '0;
        smp_ch.end_of_buffer = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_directed_cases();
        test_saturation();
        test_random_buffers(1950);

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
